// File: rtl/cmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmt_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int FIELD_W       = 11;
    localparam int EDGE_W        = 10;

    localparam logic [FIELD_W-1:0] NODE_COUNT_RST = 11'd1024;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_JOIN  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_JOINED = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LA,
        S_LB,
        S_SA,
        S_SB,
        S_WS1,
        S_WS2,
        S_WALK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/chain_cluster_merge_tracker.sv
// Chain cluster merge tracker: 1-D bond percolation with union by size.
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
// i_operation clears every cluster or joins edge i_edge_position, which
// links node p-1 and node p. Output channel (o_out_valid / i_out_stall)
// returns one result per item: largest size, merged size and status.
// i_cfg_we / i_cfg_data write the node count at any clock edge; the user
// must change it only while the block is idle; the block does not enforce it.
// A join reads both labels (S_LA, S_LB) and both sizes (S_SA, S_SB),
// writes the merged and emptied sizes (S_WS1, S_WS2), relabels the
// nodes of the smaller cluster in S_WALK and waits in S_DONE for the
// result register. Rejected joins skip ahead to S_DONE. A clear sweeps
// the label and size memories one entry a cycle. The block handles one
// item at a time and takes the next one in the cycle after the result
// is registered.
// After reset a clearing pass initializes both memories; o_in_stall
// stays high until it is done. Config writes are taken during the pass.
// The result sits in an output register; a new item is taken while it
// waits. If the receiver stalls, the next result holds in the sequencer
// until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module chain_cluster_merge_tracker #(
    parameter int MAX_NODES = cmt_pkg::MAX_NODES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [cmt_pkg::FIELD_W-1:0]  i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_operation,
    input  wire logic [cmt_pkg::EDGE_W-1:0]   i_edge_position,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [cmt_pkg::FIELD_W-1:0]       o_largest_size,
    output logic [cmt_pkg::FIELD_W-1:0]       o_merged_size,
    output logic [1:0]                        o_status
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int CW = (SW > cmt_pkg::FIELD_W) ? SW : cmt_pkg::FIELD_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);
    localparam logic [CW-1:0] MAX_CW    = CW'(MAX_NODES);

    // memories
    logic [AW-1:0] r_lbl_mem  [MAX_NODES];
    logic [SW-1:0] r_size_mem [MAX_NODES];
    logic [AW-1:0] r_lbl_q;
    logic [SW-1:0] r_size_q;

    logic          lbl_we;
    logic [AW-1:0] lbl_waddr;
    logic [AW-1:0] lbl_wdata;
    logic [AW-1:0] lbl_raddr;
    logic          size_we;
    logic [AW-1:0] size_waddr;
    logic [SW-1:0] size_wdata;
    logic [AW-1:0] size_raddr;

    cmt_pkg::t_state r_state, n_state;

    logic [cmt_pkg::FIELD_W-1:0] r_node_count;
    logic [SW-1:0]               r_largest, n_largest;
    logic [AW-1:0]               r_addr, n_addr;
    logic                        r_clr_item, n_clr_item;
    logic [CW-1:0]               r_p, n_p;
    logic [AW-1:0]               r_left, n_left;
    logic [AW-1:0]               r_right, n_right;
    logic [SW-1:0]               r_sl, n_sl;
    logic [AW-1:0]               r_large, n_large;
    logic [AW-1:0]               r_small, n_small;
    logic [SW-1:0]               r_sum, n_sum;
    logic [SW-1:0]               r_cnt, n_cnt;
    logic                        r_down, n_down;
    logic [SW-1:0]               r_res_merged, n_res_merged;
    cmt_pkg::t_status            r_res_status, n_res_status;

    logic                        r_out_valid, n_out_valid;
    logic [cmt_pkg::FIELD_W-1:0] r_out_largest, n_out_largest;
    logic [cmt_pkg::FIELD_W-1:0] r_out_merged, n_out_merged;
    logic [1:0]                  r_out_status, n_out_status;

    logic          in_xfer;
    logic          out_free;
    logic [CW-1:0] eff_count;
    logic [CW-1:0] nc_ext;
    logic [CW-1:0] p_in;
    logic          p_bad;
    logic [CW-1:0] p_minus1;
    logic          left_moves;
    logic [SW:0]   sum_full;
    logic [CW-1:0] largest_ext;
    logic [CW-1:0] merged_ext;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        nc_ext = CW'(r_node_count);
        if (nc_ext < CW'(2)) begin
            eff_count = CW'(2);
        end else if (nc_ext > MAX_CW) begin
            eff_count = MAX_CW;
        end else begin
            eff_count = nc_ext;
        end
    end

    assign p_in        = CW'(i_edge_position);
    assign p_bad       = (p_in == '0) || (p_in >= eff_count);
    assign p_minus1    = r_p - CW'(1);
    assign left_moves  = (r_sl <= r_size_q);
    assign sum_full    = {1'b0, r_sl} + {1'b0, r_size_q};
    assign largest_ext = CW'(r_largest);
    assign merged_ext  = CW'(r_res_merged);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cmt_pkg::S_CLR: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = r_clr_item ? cmt_pkg::S_DONE : cmt_pkg::S_IDLE;
                end
            end
            cmt_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_operation == cmt_pkg::OP_CLEAR) begin
                        n_state = cmt_pkg::S_CLR;
                    end else if (p_bad) begin
                        n_state = cmt_pkg::S_DONE;
                    end else begin
                        n_state = cmt_pkg::S_LA;
                    end
                end
            end
            cmt_pkg::S_LA:   n_state = cmt_pkg::S_LB;
            cmt_pkg::S_LB: begin
                n_state = (r_lbl_q == r_left) ? cmt_pkg::S_DONE : cmt_pkg::S_SA;
            end
            cmt_pkg::S_SA:   n_state = cmt_pkg::S_SB;
            cmt_pkg::S_SB:   n_state = cmt_pkg::S_WS1;
            cmt_pkg::S_WS1:  n_state = cmt_pkg::S_WS2;
            cmt_pkg::S_WS2:  n_state = cmt_pkg::S_WALK;
            cmt_pkg::S_WALK: begin
                if (r_cnt == SW'(1)) begin
                    n_state = cmt_pkg::S_DONE;
                end
            end
            cmt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = cmt_pkg::S_IDLE;
                end
            end
            default: n_state = cmt_pkg::S_CLR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        o_in_stall    = (r_state != cmt_pkg::S_IDLE);

        n_largest     = r_largest;
        n_addr        = r_addr;
        n_clr_item    = r_clr_item;
        n_p           = r_p;
        n_left        = r_left;
        n_right       = r_right;
        n_sl          = r_sl;
        n_large       = r_large;
        n_small       = r_small;
        n_sum         = r_sum;
        n_cnt         = r_cnt;
        n_down        = r_down;
        n_res_merged  = r_res_merged;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_largest = r_out_largest;
        n_out_merged  = r_out_merged;
        n_out_status  = r_out_status;

        lbl_we     = 1'b0;
        lbl_waddr  = r_addr;
        lbl_wdata  = r_addr;
        lbl_raddr  = r_p[AW-1:0];
        size_we    = 1'b0;
        size_waddr = r_addr;
        size_wdata = SW'(1);
        size_raddr = r_left;

        case (r_state)
            cmt_pkg::S_CLR: begin
                lbl_we  = 1'b1;
                size_we = 1'b1;
                n_addr  = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_largest    = SW'(1);
                    n_res_merged = '0;
                    n_res_status = cmt_pkg::ST_OK;
                end
            end
            cmt_pkg::S_IDLE: begin
                n_p       = p_in;
                lbl_raddr = p_in[AW-1:0] - AW'(1);
                if (in_xfer) begin
                    n_addr       = '0;
                    n_clr_item   = 1'b1;
                    n_res_merged = '0;
                    n_res_status = p_bad ? cmt_pkg::ST_RANGE : cmt_pkg::ST_OK;
                end
            end
            cmt_pkg::S_LA: begin
                n_left    = r_lbl_q;
                lbl_raddr = r_p[AW-1:0];
            end
            cmt_pkg::S_LB: begin
                n_right    = r_lbl_q;
                size_raddr = r_left;
                if (r_lbl_q == r_left) begin
                    n_res_status = cmt_pkg::ST_JOINED;
                end
            end
            cmt_pkg::S_SA: begin
                n_sl       = r_size_q;
                size_raddr = r_right;
            end
            cmt_pkg::S_SB: begin
                // smaller cluster moves; tie sends left into right
                n_sum        = sum_full[SW-1:0];
                n_res_merged = sum_full[SW-1:0];
                n_res_status = cmt_pkg::ST_OK;
                if (sum_full[SW-1:0] > r_largest) begin
                    n_largest = sum_full[SW-1:0];
                end
                n_down = left_moves;
                if (left_moves) begin
                    n_large = r_right;
                    n_small = r_left;
                    n_cnt   = r_sl;
                    n_addr  = p_minus1[AW-1:0];
                end else begin
                    n_large = r_left;
                    n_small = r_right;
                    n_cnt   = r_size_q;
                    n_addr  = r_p[AW-1:0];
                end
            end
            cmt_pkg::S_WS1: begin
                size_we    = 1'b1;
                size_waddr = r_large;
                size_wdata = r_sum;
            end
            cmt_pkg::S_WS2: begin
                size_we    = 1'b1;
                size_waddr = r_small;
                size_wdata = '0;
            end
            cmt_pkg::S_WALK: begin
                lbl_we    = 1'b1;
                lbl_waddr = r_addr;
                lbl_wdata = r_large;
                n_cnt     = r_cnt - SW'(1);
                n_addr    = r_down ? (r_addr - AW'(1)) : (r_addr + AW'(1));
            end
            cmt_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_largest = largest_ext[cmt_pkg::FIELD_W-1:0];
                    n_out_merged  = merged_ext[cmt_pkg::FIELD_W-1:0];
                    n_out_status  = r_res_status;
                end
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            r_lbl_mem[lbl_waddr] <= lbl_wdata;
        end
        r_lbl_q <= r_lbl_mem[lbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (size_we) begin
            r_size_mem[size_waddr] <= size_wdata;
        end
        r_size_q <= r_size_mem[size_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cmt_pkg::S_CLR;
            r_node_count <= cmt_pkg::NODE_COUNT_RST;
            r_largest    <= SW'(1);
            r_addr       <= '0;
            r_clr_item   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_largest   <= n_largest;
            r_addr      <= n_addr;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p           <= n_p;
        r_left        <= n_left;
        r_right       <= n_right;
        r_sl          <= n_sl;
        r_large       <= n_large;
        r_small       <= n_small;
        r_sum         <= n_sum;
        r_cnt         <= n_cnt;
        r_down        <= n_down;
        r_res_merged  <= n_res_merged;
        r_res_status  <= n_res_status;
        r_out_largest <= n_out_largest;
        r_out_merged  <= n_out_merged;
        r_out_status  <= n_out_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_largest_size = r_out_largest;
    assign o_merged_size  = r_out_merged;
    assign o_status       = r_out_status;

    // walk never starts or runs with an empty count
    a_walk_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmt_pkg::S_WALK) |-> (r_cnt != '0))
        else $error("relabel walk with zero count");

    // a result never reports a merge larger than the running largest
    a_merge_le_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmt_pkg::S_DONE) |-> (r_res_merged <= r_largest))
        else $error("merged size above largest");

    // rejected joins carry no merged size
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != cmt_pkg::ST_OK)) |-> (o_merged_size == '0))
        else $error("rejected item with nonzero merged size");

    // an accepted item always moves the sequencer out of the idle state
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != cmt_pkg::S_IDLE))
        else $error("sequencer stayed idle after a transfer");

endmodule

`default_nettype wire

// File: test/cluster_merge_checker.sv
`timescale 1ns / 1ps

module cluster_merge_checker #(
    parameter int MAX_NODES = cmt_pkg::MAX_NODES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [cmt_pkg::FIELD_W-1:0]  i_cfg_data,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_stall,
    input  wire logic                         i_operation,
    input  wire logic [cmt_pkg::EDGE_W-1:0]   i_edge_position,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic [cmt_pkg::FIELD_W-1:0]  i_largest_size,
    input  wire logic [cmt_pkg::FIELD_W-1:0]  i_merged_size,
    input  wire logic [1:0]                   i_status,
    output int                                o_fail_count,
    output int                                o_results_seen,
    output int                                o_outstanding
);

    typedef struct packed {
        logic [cmt_pkg::FIELD_W-1:0] largest;
        logic [cmt_pkg::FIELD_W-1:0] merged;
        cmt_pkg::t_status            status;
    } t_cluster_result;

    logic [cmt_pkg::EDGE_W-1:0]  node_label [MAX_NODES];
    logic [cmt_pkg::FIELD_W-1:0] label_size [MAX_NODES];
    logic [cmt_pkg::FIELD_W-1:0] largest_size;
    logic [cmt_pkg::FIELD_W-1:0] node_count;
    t_cluster_result             expected_results [$];

    function automatic void make_singletons();
        for (int i = 0; i < MAX_NODES; i++) begin
            node_label[i] = cmt_pkg::EDGE_W'(i);
            label_size[i] = cmt_pkg::FIELD_W'(1);
        end
        largest_size = cmt_pkg::FIELD_W'(1);
    endfunction

    function automatic int active_nodes();
        if (node_count < 2) return 2;
        if (node_count > MAX_NODES) return MAX_NODES;
        return node_count;
    endfunction

    function automatic t_cluster_result apply_item(input logic op,
                                                   input logic [cmt_pkg::EDGE_W-1:0] edge_pos);
        t_cluster_result r;
        int p;
        int left_label;
        int right_label;
        int moved;
        int m;
        p = edge_pos;
        moved = 0;
        r.merged = '0;
        r.status = cmt_pkg::ST_OK;
        if (op == cmt_pkg::OP_CLEAR) begin
            make_singletons();
        end else if (p == 0 || p >= active_nodes()) begin
            r.status = cmt_pkg::ST_RANGE;
        end else begin
            left_label  = node_label[p-1];
            right_label = node_label[p];
            if (left_label == right_label) begin
                r.status = cmt_pkg::ST_JOINED;
            end else if (label_size[left_label] <= label_size[right_label]) begin
                // left run (smaller or tied) folds into the right one, walking down
                for (m = 1; m <= label_size[left_label] && m <= p; m++) begin
                    node_label[p-m] = cmt_pkg::EDGE_W'(right_label);
                    moved++;
                end
                label_size[left_label]  = cmt_pkg::FIELD_W'(label_size[left_label] - moved);
                label_size[right_label] = cmt_pkg::FIELD_W'(label_size[right_label] + moved);
                r.merged = label_size[right_label];
            end else begin
                for (m = 1; m <= label_size[right_label] && p + m - 1 < MAX_NODES; m++) begin
                    node_label[p+m-1] = cmt_pkg::EDGE_W'(left_label);
                    moved++;
                end
                label_size[right_label] = cmt_pkg::FIELD_W'(label_size[right_label] - moved);
                label_size[left_label]  = cmt_pkg::FIELD_W'(label_size[left_label] + moved);
                r.merged = label_size[left_label];
            end
            if (r.merged > largest_size) largest_size = r.merged;
        end
        r.largest = largest_size;
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_cluster_result want;
        if (!i_rst_n) begin
            make_singletons();
            node_count = cmt_pkg::NODE_COUNT_RST;
            expected_results.delete();
        end else begin
            if (i_cfg_we) node_count = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_item(i_operation, i_edge_position));
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (expected_results.size() == 0) begin
                    flag_failure($sformatf("unexpected result: largest=%0d merged=%0d status=%0d",
                                           i_largest_size, i_merged_size, i_status));
                end else begin
                    want = expected_results.pop_front();
                    if (i_largest_size !== want.largest || i_merged_size !== want.merged ||
                        i_status !== want.status)
                        flag_failure($sformatf({"mismatch: expected largest=%0d merged=%0d ",
                                                "status=%0d, got largest=%0d merged=%0d status=%0d"},
                                               want.largest, want.merged, want.status,
                                               i_largest_size, i_merged_size, i_status));
                end
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

// File: test/chain_cluster_merge_tracker_test.sv
`timescale 1ns / 1ps

module chain_cluster_merge_tracker_test;

    localparam int LIMIT_CYCLES  = 10_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = cmt_pkg::MAX_NODES_DEF + 64;
    localparam int PHASES        = 18;
    localparam int PHASE_ITEMS   = 95;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_we        = 1'b0;
    logic [cmt_pkg::FIELD_W-1:0]   i_cfg_data      = '0;
    logic                          i_in_valid      = 1'b0;
    logic                          i_operation     = cmt_pkg::OP_CLEAR;
    logic [cmt_pkg::EDGE_W-1:0]    i_edge_position = '0;
    logic                          i_out_stall     = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [cmt_pkg::FIELD_W-1:0]   o_largest_size;
    logic [cmt_pkg::FIELD_W-1:0]   o_merged_size;
    logic [1:0]                    o_status;

    int fail_count;
    int results_seen;
    int outstanding;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;
    int hold_requests      = 0;
    int hold_served        = 0;
    int hold_left          = 0;
    int cycle_count        = 0;

    chain_cluster_merge_tracker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_edge_position (i_edge_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_largest_size  (o_largest_size),
        .o_merged_size   (o_merged_size),
        .o_status        (o_status)
    );

    cluster_merge_checker merge_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_edge_position (i_edge_position),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_largest_size  (o_largest_size),
        .i_merged_size   (o_merged_size),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_results_seen  (results_seen),
        .o_outstanding   (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when the stimulus asks for one
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    task automatic send_item(input logic op, input int edge_pos);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_edge_position <= cmt_pkg::EDGE_W'(edge_pos);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != items_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_node_count(input int value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cmt_pkg::FIELD_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly in-range joins near the low end so clusters grow and collide;
    // some clears and some joins anywhere in the edge field
    task automatic send_random(input int nodes);
        int r;
        int window;
        r = $urandom_range(99);
        if (r < 3) begin
            send_item(cmt_pkg::OP_CLEAR, $urandom_range(1023));
        end else if (r < 12) begin
            send_item(cmt_pkg::OP_JOIN, $urandom_range(1023));
        end else begin
            window = (nodes - 1 < 96) ? nodes - 1 : 96;
            if ($urandom_range(3) == 0) window = nodes - 1;
            send_item(cmt_pkg::OP_JOIN, $urandom_range(window, 1));
        end
    endtask

    initial begin
        int phase;
        int i;
        int cfg_value;
        int nodes;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset node count: full chain
        send_item(cmt_pkg::OP_JOIN, 0);
        send_item(cmt_pkg::OP_JOIN, 1);
        send_item(cmt_pkg::OP_JOIN, 1);
        send_item(cmt_pkg::OP_JOIN, 2);
        send_item(cmt_pkg::OP_JOIN, 4);
        send_item(cmt_pkg::OP_JOIN, 6);
        send_item(cmt_pkg::OP_JOIN, 5);
        send_item(cmt_pkg::OP_JOIN, 3);
        send_item(cmt_pkg::OP_JOIN, 1023);
        send_item(cmt_pkg::OP_JOIN, 1022);
        send_item(cmt_pkg::OP_JOIN, 682);
        send_item(cmt_pkg::OP_JOIN, 341);
        send_item(cmt_pkg::OP_CLEAR, 1023);
        send_item(cmt_pkg::OP_JOIN, 1023);

        write_node_count(2);
        send_item(cmt_pkg::OP_JOIN, 1);
        send_item(cmt_pkg::OP_JOIN, 1);
        send_item(cmt_pkg::OP_JOIN, 2);
        send_item(cmt_pkg::OP_JOIN, 1023);

        // below and above the legal count range
        write_node_count(0);
        send_item(cmt_pkg::OP_JOIN, 1);
        send_item(cmt_pkg::OP_JOIN, 2);
        write_node_count(2047);
        send_item(cmt_pkg::OP_JOIN, 1023);
        send_item(cmt_pkg::OP_JOIN, 1000);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 6)
                0: cfg_value = $urandom_range(12, 2);
                1: cfg_value = $urandom_range(64, 13);
                2: cfg_value = cmt_pkg::MAX_NODES_DEF;
                3: cfg_value = $urandom_range(40, 2);
                4: cfg_value = $urandom_range(300, 65);
                default: begin
                    case ($urandom_range(4))
                        0: cfg_value = 0;
                        1: cfg_value = 1;
                        2: cfg_value = 2;
                        3: cfg_value = 1025;
                        default: cfg_value = 2047;
                    endcase
                end
            endcase
            write_node_count(cfg_value);
            nodes = (cfg_value < 2) ? 2 :
                    (cfg_value > cmt_pkg::MAX_NODES_DEF) ? cmt_pkg::MAX_NODES_DEF : cfg_value;

            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
            endcase

            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 0 && i == 30) hold_requests++;
                if (phase == 1 && i == 50) wait_drained();
                send_random(nodes);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
